// ----- hw/rtl/byte_ring_with_peek_commit_defines.svh -----
// Assertion helpers shared by the RTL files.
`ifndef BYTE_RING_WITH_PEEK_COMMIT_DEFINES_SVH
`define BYTE_RING_WITH_PEEK_COMMIT_DEFINES_SVH

`ifndef SYNTHESIS
`define BRPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BRPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BRPC_ASSERT(lbl, prop, msg)
`define BRPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/brpc_pkg.sv -----
package brpc_pkg;

    localparam int RING_DEPTH_DEF = 256;
    localparam int CMD_W          = 3;
    localparam int DATA_W         = 8;
    localparam int COUNT_W        = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_PEEK   = 3'd2,
        CMD_REWIND = 3'd3,
        CMD_COMMIT = 3'd4
    } cmd_e_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctrl_t;

    typedef struct packed {
        logic               hit;
        logic               overflow;
        logic [COUNT_W-1:0] bytes_ready;
        logic [COUNT_W-1:0] peek_ready;
    } step_stat_t;

endpackage

// ----- hw/rtl/brpc_if.sv -----
interface brpc_req_if;
    import brpc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] push_data;

    modport source (output valid, output command, output push_data, input ready);
    modport sink   (input valid, input command, input push_data, output ready);
endinterface

interface brpc_rsp_if;
    import brpc_pkg::*;

    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  read_data;
    logic               read_valid;
    logic [COUNT_W-1:0] bytes_ready;
    logic [COUNT_W-1:0] peek_ready;
    logic               overflow;

    modport source (output valid, output read_data, output read_valid, output bytes_ready,
                    output peek_ready, output overflow, input ready);
    modport sink   (input valid, input read_data, input read_valid, input bytes_ready,
                    input peek_ready, input overflow, output ready);
endinterface

// ----- hw/rtl/brpc_mem.sv -----
module brpc_mem #(
    parameter int DEPTH  = brpc_pkg::RING_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  brpc_pkg::mem_ctrl_t        ctrl,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [brpc_pkg::DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0]          raddr,
    output logic [brpc_pkg::DATA_W-1:0] rdata
);
    import brpc_pkg::*;

    logic [DATA_W-1:0] store [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            store[waddr] <= wdata;
        end
        if (ctrl.re)
        begin
            rdata_reg <= store[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- hw/rtl/brpc_ptr.sv -----
`include "byte_ring_with_peek_commit_defines.svh"

module brpc_ptr #(
    parameter int DEPTH = brpc_pkg::RING_DEPTH_DEF,
    parameter int PTR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [brpc_pkg::CMD_W-1:0]  command,
    output brpc_pkg::mem_ctrl_t         mem_ctrl,
    output logic [PTR_W-1:0]            waddr,
    output logic [PTR_W-1:0]            raddr,
    output brpc_pkg::step_stat_t        stat
);
    import brpc_pkg::*;

    localparam int               EXT_W    = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;
    localparam logic [PTR_W-1:0] LAST     = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(DEPTH);

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] pk_ptr_reg, pk_ptr_next;
    logic             full;
    logic             hit;
    logic             ovf;
    mem_ctrl_t        ctrl;
    logic             use_peek;

    function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
        ring_inc = (p == LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [COUNT_W-1:0] ring_dist(input logic [PTR_W-1:0] from,
                                                     input logic [PTR_W-1:0] to);
        logic [PTR_W:0] diff;
        logic [EXT_W-1:0] ext;
        diff = {1'b0, to} - {1'b0, from};
        if (diff[PTR_W])
        begin
            diff = diff + DEPTH_X;
        end
        ext = EXT_W'(diff[PTR_W-1:0]);
        ring_dist = ext[COUNT_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ring_dist_full(input logic [PTR_W-1:0] from,
                                                         input logic [PTR_W-1:0] to);
        logic [PTR_W:0] diff;
        diff = {1'b0, to} - {1'b0, from};
        if (diff[PTR_W])
        begin
            diff = diff + DEPTH_X;
        end
        ring_dist_full = diff[PTR_W-1:0];
    endfunction

    assign full = (ring_dist(rd_ptr_reg, wr_ptr_reg) == COUNT_W'(DEPTH - 1))
                  && (EXT_W'(ring_dist_full(rd_ptr_reg, wr_ptr_reg)) == EXT_W'(LAST));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        pk_ptr_next = pk_ptr_reg;
        ctrl        = '0;
        hit         = 1'b0;
        ovf         = 1'b0;
        use_peek    = 1'b0;
        unique case (command)
            CMD_PUSH:
            begin
                if (full)
                begin
                    ovf = 1'b1;
                end
                else
                begin
                    ctrl.we     = 1'b1;
                    wr_ptr_next = ring_inc(wr_ptr_reg);
                end
            end
            CMD_POP:
            begin
                if (rd_ptr_reg != wr_ptr_reg)
                begin
                    ctrl.re     = 1'b1;
                    hit         = 1'b1;
                    rd_ptr_next = ring_inc(rd_ptr_reg);
                end
            end
            CMD_PEEK:
            begin
                use_peek = 1'b1;
                if (pk_ptr_reg != wr_ptr_reg)
                begin
                    ctrl.re     = 1'b1;
                    hit         = 1'b1;
                    pk_ptr_next = ring_inc(pk_ptr_reg);
                end
            end
            CMD_REWIND:
            begin
                pk_ptr_next = rd_ptr_reg;
            end
            CMD_COMMIT:
            begin
                rd_ptr_next = pk_ptr_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            pk_ptr_reg <= '0;
        end
        else if (accept)
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            pk_ptr_reg <= pk_ptr_next;
        end
    end

    assign mem_ctrl.we      = accept && ctrl.we;
    assign mem_ctrl.re      = accept && ctrl.re;
    assign waddr            = wr_ptr_reg;
    assign raddr            = use_peek ? pk_ptr_reg : rd_ptr_reg;
    assign stat.hit         = hit;
    assign stat.overflow    = ovf;
    assign stat.bytes_ready = ring_dist(rd_ptr_next, wr_ptr_next);
    assign stat.peek_ready  = ring_dist(pk_ptr_next, wr_ptr_next);

    `BRPC_ASSERT(a_ptr_range,
        (wr_ptr_reg <= LAST) && (rd_ptr_reg <= LAST) && (pk_ptr_reg <= LAST),
        "pointer beyond ring depth")
    `BRPC_ASSERT_NEXT(a_full_hold,
        accept && (command == CMD_PUSH) && full,
        $stable(wr_ptr_reg), "refused push moved write pointer")
    `BRPC_ASSERT_NEXT(a_pop_moves,
        accept && (command == CMD_POP) && (rd_ptr_reg != wr_ptr_reg),
        rd_ptr_reg != $past(rd_ptr_reg), "pop did not advance read pointer")
endmodule

// ----- hw/rtl/byte_ring_with_peek_commit.sv -----
// Byte ring with a committed read pointer and a speculative peek pointer.
// req channel: one command per beat (push, pop, peek, rewind peek, commit
//   peek) with the byte to store on push.
// rsp channel: exactly one result beat per command, in order: the byte read
//   by pop or peek with read_valid, the byte counts seen from the read and
//   peek pointers after the command, and overflow for a refused push.
// Timing: the result of an accepted command is registered and valid in the
//   cycle after it is accepted. One command per cycle sustained while rsp is
//   ready; the registered read of the byte memory sets this timing.
// The ring holds at most RING_DEPTH-1 bytes; a push beyond that is dropped.
// Reset clears all three pointers, so the ring starts empty; the byte memory
//   is not cleared and needs no sweep.
// When rsp is stalled, the pending result is held in the output register and
//   req.ready drops until it is taken; a new command is taken in the same
//   cycle as the old result leaves.
`include "byte_ring_with_peek_commit_defines.svh"

module byte_ring_with_peek_commit #(
    parameter int RING_DEPTH = brpc_pkg::RING_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    brpc_req_if.sink    req,
    brpc_rsp_if.source  rsp
);
    import brpc_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);

    logic               accept;
    mem_ctrl_t          mem_ctrl;
    logic [PTR_W-1:0]   waddr;
    logic [PTR_W-1:0]   raddr;
    logic [DATA_W-1:0]  mem_rdata;
    step_stat_t         stat;

    logic               out_valid_reg;
    logic               hit_reg;
    logic               overflow_reg;
    logic [COUNT_W-1:0] bytes_ready_reg;
    logic [COUNT_W-1:0] peek_ready_reg;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    brpc_ptr #(
        .DEPTH (RING_DEPTH),
        .PTR_W (PTR_W)
    ) u_ptr (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .command  (req.command),
        .mem_ctrl (mem_ctrl),
        .waddr    (waddr),
        .raddr    (raddr),
        .stat     (stat)
    );

    brpc_mem #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W)
    ) u_mem (
        .clk   (clk),
        .ctrl  (mem_ctrl),
        .waddr (waddr),
        .wdata (req.push_data),
        .raddr (raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            out_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg         <= stat.hit;
            overflow_reg    <= stat.overflow;
            bytes_ready_reg <= stat.bytes_ready;
            peek_ready_reg  <= stat.peek_ready;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_valid  = hit_reg;
    assign rsp.read_data   = hit_reg ? mem_rdata : '0;
    assign rsp.overflow    = overflow_reg;
    assign rsp.bytes_ready = bytes_ready_reg;
    assign rsp.peek_ready  = peek_ready_reg;

    `BRPC_ASSERT(a_stall_blocks, !(rsp.valid && !rsp.ready) || !req.ready, "command taken while result stalled")
    `BRPC_ASSERT(a_ovf_no_read, !(rsp.valid && rsp.overflow) || !rsp.read_valid, "overflow and read data in one result")
    `BRPC_ASSERT_NEXT(a_result_follows, accept, rsp.valid, "accepted command gave no result")
endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import brpc_pkg::*;

    localparam int DEPTH       = RING_DEPTH_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int HOLD_CYCLES = 100;
    localparam logic [CMD_W-1:0] CMD_LAST = '1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] push_data;
    } ring_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               read_valid;
        logic [COUNT_W-1:0] bytes_ready;
        logic [COUNT_W-1:0] peek_ready;
        logic               overflow;
    } ring_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    brpc_req_if req_ch ();
    brpc_rsp_if rsp_ch ();

    byte_ring_with_peek_commit #(
        .RING_DEPTH (DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    ring_cmd_t    cmds_to_send[$];
    ring_result_t results_due[$];
    ring_cmd_t    next_cmd;
    ring_result_t got_result;
    ring_result_t want_result;

    logic [DATA_W-1:0] ring_bytes[DEPTH];
    int wr_ptr;
    int rd_ptr;
    int pk_ptr;

    int send_idle_pct;
    int recv_idle_pct;
    logic rsp_hold;
    int quiet_cycles;
    int error_count;
    int cmds_accepted;
    int results_checked;
    int refused_pushes;
    int empty_reads;
    int backward_commits;
    int bytes_read;

    function automatic logic [COUNT_W-1:0] ring_span(int from_ptr, int to_ptr);
        return COUNT_W'((to_ptr + DEPTH - from_ptr) % DEPTH);
    endfunction

    function automatic ring_result_t predict_ring_result(ring_cmd_t c);
        ring_result_t r;
        r = '0;
        case (c.command)
            CMD_PUSH:
            begin
                if (int'(ring_span(rd_ptr, wr_ptr)) >= DEPTH - 1)
                begin
                    r.overflow = 1'b1;
                    refused_pushes++;
                end
                else
                begin
                    ring_bytes[wr_ptr] = c.push_data;
                    wr_ptr = (wr_ptr + 1) % DEPTH;
                end
            end
            CMD_POP:
            begin
                if (rd_ptr != wr_ptr)
                begin
                    r.read_data  = ring_bytes[rd_ptr];
                    r.read_valid = 1'b1;
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    bytes_read++;
                end
                else
                begin
                    empty_reads++;
                end
            end
            CMD_PEEK:
            begin
                if (pk_ptr != wr_ptr)
                begin
                    r.read_data  = ring_bytes[pk_ptr];
                    r.read_valid = 1'b1;
                    pk_ptr = (pk_ptr + 1) % DEPTH;
                    bytes_read++;
                end
                else
                begin
                    empty_reads++;
                end
            end
            CMD_REWIND:
            begin
                pk_ptr = rd_ptr;
            end
            CMD_COMMIT:
            begin
                if (ring_span(pk_ptr, wr_ptr) > ring_span(rd_ptr, wr_ptr))
                begin
                    backward_commits++;
                end
                rd_ptr = pk_ptr;
            end
            default:
            begin
            end
        endcase
        r.bytes_ready = ring_span(rd_ptr, wr_ptr);
        r.peek_ready  = ring_span(pk_ptr, wr_ptr);
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    task automatic add_cmd(logic [CMD_W-1:0] c, logic [DATA_W-1:0] d);
        ring_cmd_t item;
        item.command   = c;
        item.push_data = d;
        cmds_to_send.push_back(item);
    endtask

    // mode 0 leans to pushes, 1 to reads, 2 is balanced
    function automatic logic [CMD_W-1:0] pick_cmd(int mode);
        int roll;
        int push_cut;
        int pop_cut;
        int peek_cut;
        int rewind_cut;
        int commit_cut;
        roll = $urandom_range(0, 99);
        case (mode)
            0:
            begin
                push_cut = 60; pop_cut = 75; peek_cut = 90; rewind_cut = 94; commit_cut = 98;
            end
            1:
            begin
                push_cut = 20; pop_cut = 55; peek_cut = 85; rewind_cut = 91; commit_cut = 97;
            end
            default:
            begin
                push_cut = 35; pop_cut = 60; peek_cut = 85; rewind_cut = 91; commit_cut = 97;
            end
        endcase
        if (roll < push_cut)
            return CMD_PUSH;
        else if (roll < pop_cut)
            return CMD_POP;
        else if (roll < peek_cut)
            return CMD_PEEK;
        else if (roll < rewind_cut)
            return CMD_REWIND;
        else if (roll < commit_cut)
            return CMD_COMMIT;
        else
            return CMD_W'($urandom_range(int'(CMD_COMMIT) + 1, int'(CMD_LAST)));
    endfunction

    task automatic add_random(int count);
        int mode;
        int left;
        mode = 2;
        left = 0;
        repeat (count)
        begin
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 60);
            end
            left--;
            add_cmd(pick_cmd(mode), DATA_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_drained();
        while (cmds_to_send.size() != 0 || req_ch.valid || results_due.size() != 0)
            @(posedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                next_cmd.command   = req_ch.command;
                next_cmd.push_data = req_ch.push_data;
                results_due.push_back(predict_ring_result(next_cmd));
                cmds_accepted++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (cmds_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_cmd = cmds_to_send.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.command   <= next_cmd.command;
                    req_ch.push_data <= next_cmd.push_data;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got_result.read_data   = rsp_ch.read_data;
                got_result.read_valid  = rsp_ch.read_valid;
                got_result.bytes_ready = rsp_ch.bytes_ready;
                got_result.peek_ready  = rsp_ch.peek_ready;
                got_result.overflow    = rsp_ch.overflow;
                if (results_due.size() == 0)
                begin
                    $error("result beat with no command pending");
                    error_count++;
                end
                else
                begin
                    want_result = results_due.pop_front();
                    check_field("read_data", want_result.read_data, got_result.read_data);
                    check_field("read_valid", want_result.read_valid, got_result.read_valid);
                    check_field("bytes_ready", want_result.bytes_ready,
                                got_result.bytes_ready);
                    check_field("peek_ready", want_result.peek_ready, got_result.peek_ready);
                    check_field("overflow", want_result.overflow, got_result.overflow);
                    results_checked++;
                end
            end
            rsp_ch.ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // long result stall while commands keep coming, so req backs up
    initial
    begin
        rsp_hold = 1'b0;
        while (cmds_accepted < 40)
            @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    initial
    begin
        req_ch.valid     = 1'b0;
        req_ch.command   = CMD_PUSH;
        req_ch.push_data = '0;
        rsp_ch.ready     = 1'b0;
        wr_ptr = 0;
        rd_ptr = 0;
        pk_ptr = 0;
        quiet_cycles = 0;
        error_count = 0;
        cmds_accepted = 0;
        results_checked = 0;
        refused_pushes = 0;
        empty_reads = 0;
        backward_commits = 0;
        bytes_read = 0;
        send_idle_pct = 12;
        recv_idle_pct = 50;

        // reads on an empty ring, peek falling behind pop, commit moving read back, rewind, unused command codes
        add_cmd(CMD_POP, 8'h00);
        add_cmd(CMD_PEEK, 8'h00);
        add_cmd(CMD_PUSH, 8'h00);
        add_cmd(CMD_PUSH, 8'hFF);
        add_cmd(CMD_PUSH, 8'hA5);
        add_cmd(CMD_PEEK, 8'hFF);
        add_cmd(CMD_POP, 8'h00);
        add_cmd(CMD_POP, 8'h00);
        add_cmd(CMD_POP, 8'h00);
        add_cmd(CMD_COMMIT, 8'hFF);
        add_cmd(CMD_PEEK, 8'h00);
        add_cmd(CMD_REWIND, 8'hFF);
        add_cmd(CMD_POP, 8'h00);
        add_cmd(CMD_PEEK, 8'h00);
        add_cmd(CMD_COMMIT + 3'd1, 8'hFF);
        add_cmd(CMD_COMMIT + 3'd2, 8'h5A);
        add_cmd(CMD_LAST, 8'hFF);
        add_cmd(CMD_POP, 8'h00);
        add_cmd(CMD_POP, 8'h00);
        add_cmd(CMD_PEEK, 8'h00);
        add_cmd(CMD_PEEK, 8'h00);
        add_cmd(CMD_PUSH, 8'h5A);
        add_cmd(CMD_POP, 8'h00);
        add_random(480);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        send_idle_pct = 50;
        recv_idle_pct = 12;
        add_random(480);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // fill past full, drain through the peek pointer, then pop the rest
        repeat (DEPTH + 2)
            add_cmd(CMD_PUSH, DATA_W'($urandom_range(0, 255)));
        add_cmd(CMD_REWIND, 8'h00);
        repeat (150)
            add_cmd(CMD_PEEK, 8'h00);
        add_cmd(CMD_COMMIT, 8'h00);
        repeat (120)
            add_cmd(CMD_POP, 8'h00);
        add_random(150);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d commands, checked %0d results, %0d bytes read back",
                 cmds_accepted, results_checked, bytes_read);
        $display("%0d pushes refused on a full ring, %0d reads of an empty view, %0d commits back",
                 refused_pushes, empty_reads, backward_commits);
        if (error_count == 0 && results_due.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
